[rtl/jan_pkg.sv]
// shared constants, register codes and beat types for the joystick axis normalizer
// no dependencies
package jan_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int FRAC_BITS   = 14;
    localparam int TRIM_BITS   = 15;
    localparam int BAND_BITS   = 14;
    localparam int POS_BITS    = 16;
    localparam int ADDR_BITS   = 5;
    localparam int DATA_BITS   = 32;

    localparam logic [2:0] REG_X_MIN  = 3'd0;
    localparam logic [2:0] REG_X_MAX  = 3'd1;
    localparam logic [2:0] REG_Y_MIN  = 3'd2;
    localparam logic [2:0] REG_Y_MAX  = 3'd3;
    localparam logic [2:0] REG_X_TRIM = 3'd4;
    localparam logic [2:0] REG_Y_TRIM = 3'd5;
    localparam logic [2:0] REG_X_BAND = 3'd6;
    localparam logic [2:0] REG_Y_BAND = 3'd7;

    localparam logic [SAMPLE_BITS-1:0] MAX_VOLTS_RESET = SAMPLE_BITS'(3300);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] x_sample;
        logic [SAMPLE_BITS-1:0] y_sample;
    } in_beat_t;

    typedef struct packed {
        logic signed [POS_BITS-1:0] x_position;
        logic signed [POS_BITS-1:0] y_position;
    } out_beat_t;

endpackage

[rtl/joystick_axis_normalizer.sv]
// throughput: one sample pair per cycle while in_stall is low; the two restoring dividers retire one bit per stage
// a one-entry skid behind the output register keeps the input open under an output stall until the skid fills
// reset: valid bits and skid clear, registers return to min 0, max 3300, trim 0, band 0
// top level: APB register file, valid/skid control, two jan_axis datapaths; uses jan_pkg
module joystick_axis_normalizer #(
    parameter int FRAC_BITS = jan_pkg::FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [jan_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [jan_pkg::DATA_BITS-1:0]   pwdata,
    output logic [jan_pkg::DATA_BITS-1:0]   prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  jan_pkg::in_beat_t               in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output jan_pkg::out_beat_t              out_data
);
    import jan_pkg::*;

    localparam int NSTG = 2 * FRAC_BITS + 5;

    logic [SAMPLE_BITS-1:0]      x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic signed [TRIM_BITS-1:0] x_trim_reg, y_trim_reg;
    logic [BAND_BITS-1:0]        x_band_reg, y_band_reg;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg  <= '0;
            x_max_reg  <= MAX_VOLTS_RESET;
            y_min_reg  <= '0;
            y_max_reg  <= MAX_VOLTS_RESET;
            x_trim_reg <= '0;
            y_trim_reg <= '0;
            x_band_reg <= '0;
            y_band_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[4:2])
                REG_X_MIN:  x_min_reg  <= pwdata[SAMPLE_BITS-1:0];
                REG_X_MAX:  x_max_reg  <= pwdata[SAMPLE_BITS-1:0];
                REG_Y_MIN:  y_min_reg  <= pwdata[SAMPLE_BITS-1:0];
                REG_Y_MAX:  y_max_reg  <= pwdata[SAMPLE_BITS-1:0];
                REG_X_TRIM: x_trim_reg <= pwdata[TRIM_BITS-1:0];
                REG_Y_TRIM: y_trim_reg <= pwdata[TRIM_BITS-1:0];
                REG_X_BAND: x_band_reg <= pwdata[BAND_BITS-1:0];
                REG_Y_BAND: y_band_reg <= pwdata[BAND_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_X_MIN:  prdata = DATA_BITS'(x_min_reg);
            REG_X_MAX:  prdata = DATA_BITS'(x_max_reg);
            REG_Y_MIN:  prdata = DATA_BITS'(y_min_reg);
            REG_Y_MAX:  prdata = DATA_BITS'(y_max_reg);
            REG_X_TRIM: prdata = DATA_BITS'($unsigned(x_trim_reg));
            REG_Y_TRIM: prdata = DATA_BITS'($unsigned(y_trim_reg));
            REG_X_BAND: prdata = DATA_BITS'(x_band_reg);
            REG_Y_BAND: prdata = DATA_BITS'(y_band_reg);
            default:    prdata = '0;
        endcase
    end

    // pipeline moves as a whole while the skid is empty
    logic            en;
    logic [NSTG-1:0] valid_reg;
    logic            skid_valid_reg;
    out_beat_t       skid_reg;
    out_beat_t       out_reg;
    logic            out_valid_reg;
    out_beat_t       pipe_data;
    logic            out_ready;

    assign en        = !skid_valid_reg;
    assign in_stall  = skid_valid_reg;
    assign out_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[NSTG-2:0], in_valid};
    end

    jan_axis #(.FRAC_BITS(FRAC_BITS)) u_x (
        .clk      (clk),
        .en       (en),
        .sample   (in_data.x_sample),
        .vmin     (x_min_reg),
        .vmax     (x_max_reg),
        .trim     (x_trim_reg),
        .band     (x_band_reg),
        .position (pipe_data.x_position)
    );

    jan_axis #(.FRAC_BITS(FRAC_BITS)) u_y (
        .clk      (clk),
        .en       (en),
        .sample   (in_data.y_sample),
        .vmin     (y_min_reg),
        .vmax     (y_max_reg),
        .trim     (y_trim_reg),
        .band     (y_band_reg),
        .position (pipe_data.y_position)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= valid_reg[NSTG-1];
        end
        else if (en && valid_reg[NSTG-1])
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
            out_reg <= skid_valid_reg ? skid_reg : pipe_data;
        else if (en && valid_reg[NSTG-1])
            skid_reg <= pipe_data;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

[rtl/jan_axis.sv]
// one axis datapath: normalize, clamp, trim, dead zone, saturate
// two bit-per-stage restoring dividers; uses jan_pkg
module jan_axis #(
    parameter int FRAC_BITS = jan_pkg::FRAC_BITS
) (
    input  logic                                    clk,
    input  logic                                    en,
    input  logic [jan_pkg::SAMPLE_BITS-1:0]         sample,
    input  logic [jan_pkg::SAMPLE_BITS-1:0]         vmin,
    input  logic [jan_pkg::SAMPLE_BITS-1:0]         vmax,
    input  logic signed [jan_pkg::TRIM_BITS-1:0]    trim,
    input  logic [jan_pkg::BAND_BITS-1:0]           band,
    output logic signed [jan_pkg::POS_BITS-1:0]     position
);
    import jan_pkg::*;

    localparam int F    = FRAC_BITS;
    localparam int SB   = SAMPLE_BITS;
    localparam int NW   = SB + 2;
    localparam int VW   = ((F + 2 > TRIM_BITS) ? F + 2 : TRIM_BITS) + 1;
    localparam int BCW  = (BAND_BITS > F + 1) ? BAND_BITS : F + 1;
    localparam int CW   = (F + 3 > 17) ? F + 3 : 17;
    localparam int ONE  = 1 << F;
    localparam int LIM_P = (2 * ONE - 1 < 32767) ? 2 * ONE - 1 : 32767;
    localparam int LIM_N = (2 * ONE < 32768) ? 2 * ONE : 32768;

    typedef struct packed {
        logic [SB-1:0] ud;
        logic          neg;
        logic          zero;
        logic          big;
    } d1_side_t;

    typedef struct packed {
        logic [F:0] d2;
        logic       vneg;
        logic       dz;
        logic       big;
    } d2_side_t;

    // stage 0: operands of the first division
    logic signed [NW-1:0] num_c;
    logic signed [SB:0]   den_c;
    logic [NW-1:0]        unum_c;
    logic [SB:0]          uden_c;

    logic [SB-1:0]   r1_reg [0:F];
    logic [F-1:0]    q1_reg [0:F];
    d1_side_t        s1_reg [0:F];

    always_comb
    begin
        num_c  = $signed({1'b0, sample, 1'b0}) - $signed({2'b00, vmin})
               - $signed({2'b00, vmax});
        den_c  = $signed({1'b0, vmax}) - $signed({1'b0, vmin});
        unum_c = num_c[NW-1] ? NW'(-num_c) : NW'(num_c);
        uden_c = den_c[SB] ? (SB+1)'(-den_c) : (SB+1)'(den_c);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg[0]      <= unum_c[SB-1:0];
            q1_reg[0]      <= '0;
            s1_reg[0].ud   <= uden_c[SB-1:0];
            s1_reg[0].neg  <= num_c[NW-1] ^ den_c[SB];
            s1_reg[0].zero <= (den_c == '0);
            // quotient reaches one whenever |num| >= |den|
            s1_reg[0].big  <= ({1'b0, unum_c} >= {2'b00, uden_c});
        end
    end

    genvar k;
    generate
        for (k = 1; k <= F; k++)
        begin : g_div1
            logic [SB:0] rs;
            logic        ge;
            always_comb
            begin
                rs = {r1_reg[k-1], 1'b0};
                ge = (rs >= {1'b0, s1_reg[k-1].ud});
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r1_reg[k] <= ge ? SB'(rs - {1'b0, s1_reg[k-1].ud}) : rs[SB-1:0];
                    q1_reg[k] <= {q1_reg[k-1][F-2:0], ge};
                    s1_reg[k] <= s1_reg[k-1];
                end
            end
        end
    endgenerate

    // round, clamp to one, apply sign and trim
    logic [F:0]           mag_c;
    logic signed [VW-1:0] norm_c;
    logic signed [VW-1:0] v_reg;

    always_comb
    begin
        mag_c = {1'b0, q1_reg[F]}
              + (F+1)'(r1_reg[F] >= (s1_reg[F].ud - (s1_reg[F].ud >> 1)));
        if (s1_reg[F].zero)
            mag_c = '0;
        else if (s1_reg[F].big)
            mag_c = (F+1)'(ONE);
        norm_c = s1_reg[F].neg ? -$signed(VW'(mag_c)) : $signed(VW'(mag_c));
    end

    always_ff @(posedge clk)
    begin
        if (en)
            v_reg <= norm_c - VW'(trim);
    end

    // dead zone compare and operands of the second division
    logic [BCW-1:0] band_c;
    logic [VW-1:0]  a_c;
    logic [VW:0]    twice_c;
    logic [VW-1:0]  diff_reg;
    d2_side_t       s2_c;
    d2_side_t       s2_head_reg;

    always_comb
    begin
        band_c = (BCW'(band) >= BCW'(ONE)) ? BCW'(ONE - 1) : BCW'(band);
        a_c    = v_reg[VW-1] ? VW'(-v_reg) : VW'(v_reg);
        s2_c.d2   = (F+1)'(ONE) - (F+1)'(band_c);
        s2_c.vneg = v_reg[VW-1];
        s2_c.dz   = ((VW+BCW)'(a_c) <= (VW+BCW)'(band_c));
        twice_c   = {(VW+1)'(s2_c.d2)} << 1;
        s2_c.big  = ({1'b0, VW'(a_c - VW'(band_c))} >= twice_c);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg    <= a_c - VW'(band_c);
            s2_head_reg <= s2_c;
        end
    end

    logic [F:0]  r2_reg [0:F];
    logic [F:0]  q2_reg [0:F];
    d2_side_t    s3_reg [0:F];

    // integer bit of the second quotient, no shift
    logic ge0_c;
    always_comb
    begin
        ge0_c = (diff_reg >= VW'(s2_head_reg.d2));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r2_reg[0] <= ge0_c ? (F+1)'(diff_reg - VW'(s2_head_reg.d2)) : (F+1)'(diff_reg);
            q2_reg[0] <= (F+1)'(ge0_c);
            s3_reg[0] <= s2_head_reg;
        end
    end

    generate
        for (k = 1; k <= F; k++)
        begin : g_div2
            logic [F+1:0] rs;
            logic         ge;
            always_comb
            begin
                rs = {r2_reg[k-1], 1'b0};
                ge = (rs >= {1'b0, s3_reg[k-1].d2});
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r2_reg[k] <= ge ? (F+1)'(rs - {1'b0, s3_reg[k-1].d2}) : rs[F:0];
                    q2_reg[k] <= {q2_reg[k-1][F-1:0], ge};
                    s3_reg[k] <= s3_reg[k-1];
                end
            end
        end
    endgenerate

    // round, clamp to two, dead zone, saturate
    logic [F+1:0]  m_c;
    logic [CW-1:0] sat_c;
    logic signed [POS_BITS-1:0] pos_next;
    logic signed [POS_BITS-1:0] pos_reg;

    always_comb
    begin
        m_c = {1'b0, q2_reg[F]}
            + (F+2)'(r2_reg[F] >= (s3_reg[F].d2 - (s3_reg[F].d2 >> 1)));
        if (s3_reg[F].big)
            m_c = (F+2)'(2 * ONE);
        sat_c = CW'(m_c);
        if (s3_reg[F].vneg)
        begin
            if (sat_c > CW'(LIM_N))
                sat_c = CW'(LIM_N);
            pos_next = POS_BITS'(-$signed({1'b0, sat_c}));
        end
        else
        begin
            if (sat_c > CW'(LIM_P))
                sat_c = CW'(LIM_P);
            pos_next = POS_BITS'(sat_c);
        end
        if (s3_reg[F].dz)
            pos_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            pos_reg <= pos_next;
    end

    assign position = pos_reg;

endmodule

[rtl/jan_checker.sv]
// port-level checks for joystick_axis_normalizer, bound to the top level
// uses jan_pkg beat types
module jan_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input jan_pkg::out_beat_t  out_data
);
    import jan_pkg::*;

    // input only closes while a result is held at the output
    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stall rose without an output stall");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output beat changed");

    a_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid && !in_stall)
        else $error("handshake active in reset");

endmodule

bind joystick_axis_normalizer jan_checker u_jan_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

[tb/sv/axis_checker.sv]
`timescale 1ns / 100ps
// checker for the joystick axis normalizer: predicts each output beat from the input beats
// and the register writes it sees on the apb port; uses jan_pkg
module axis_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [jan_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [jan_pkg::DATA_BITS-1:0]   pwdata,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  jan_pkg::in_beat_t               in_data,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  jan_pkg::out_beat_t              out_data,
    output int                              fail_count,
    output int                              pending_positions
);
    import jan_pkg::*;

    logic [SAMPLE_BITS-1:0] min_volts [2];
    logic [SAMPLE_BITS-1:0] max_volts [2];
    logic [TRIM_BITS-1:0]   trim [2];
    logic [BAND_BITS-1:0]   band [2];
    out_beat_t              position_queue [$];

    function automatic logic signed [POS_BITS-1:0] condition_axis(
        input logic [SAMPLE_BITS-1:0] sample,
        input logic [SAMPLE_BITS-1:0] vmin,
        input logic [SAMPLE_BITS-1:0] vmax,
        input logic [TRIM_BITS-1:0]   trim_bits,
        input logic [BAND_BITS-1:0]   band_bits
    );
        longint one;
        longint num;
        longint den;
        longint un;
        longint ud;
        longint mag;
        longint norm;
        longint v;
        longint a;
        longint b;
        longint m;
        longint result;
        one = longint'(1) << FRAC_BITS;
        num = 2 * longint'(sample) - (longint'(vmin) + longint'(vmax));
        den = longint'(vmax) - longint'(vmin);
        norm = 0;
        if (den != 0)
        begin
            un = num < 0 ? -num : num;
            ud = den < 0 ? -den : den;
            mag = ((un << FRAC_BITS) + ud / 2) / ud;
            if (mag > one)
                mag = one;
            norm = ((num < 0) != (den < 0)) ? -mag : mag;
        end
        v = norm - longint'($signed(trim_bits));
        b = longint'(band_bits);
        if (b >= one)
            b = one - 1;
        a = v < 0 ? -v : v;
        if (a <= b)
            result = 0;
        else
        begin
            m = (((a - b) << FRAC_BITS) + (one - b) / 2) / (one - b);
            if (m > 2 * one)
                m = 2 * one;
            result = v < 0 ? -m : m;
        end
        if (result > 2 * one - 1)
            result = 2 * one - 1;
        if (result < -2 * one)
            result = -2 * one;
        if (result > 32767)
            result = 32767;
        if (result < -32768)
            result = -32768;
        return POS_BITS'(result);
    endfunction

    assign pending_positions = position_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        logic [2:0] reg_index;
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            min_volts[0] <= '0;
            min_volts[1] <= '0;
            max_volts[0] <= MAX_VOLTS_RESET;
            max_volts[1] <= MAX_VOLTS_RESET;
            trim[0] <= '0;
            trim[1] <= '0;
            band[0] <= '0;
            band[1] <= '0;
            fail_count <= 0;
            position_queue.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                reg_index = paddr[4:2];
                case (reg_index)
                    REG_X_MIN:  min_volts[0] <= pwdata[SAMPLE_BITS-1:0];
                    REG_X_MAX:  max_volts[0] <= pwdata[SAMPLE_BITS-1:0];
                    REG_Y_MIN:  min_volts[1] <= pwdata[SAMPLE_BITS-1:0];
                    REG_Y_MAX:  max_volts[1] <= pwdata[SAMPLE_BITS-1:0];
                    REG_X_TRIM: trim[0] <= pwdata[TRIM_BITS-1:0];
                    REG_Y_TRIM: trim[1] <= pwdata[TRIM_BITS-1:0];
                    REG_X_BAND: band[0] <= pwdata[BAND_BITS-1:0];
                    REG_Y_BAND: band[1] <= pwdata[BAND_BITS-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                want.x_position = condition_axis(in_data.x_sample, min_volts[0],
                                                 max_volts[0], trim[0], band[0]);
                want.y_position = condition_axis(in_data.y_sample, min_volts[1],
                                                 max_volts[1], trim[1], band[1]);
                position_queue.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                if (position_queue.size() == 0)
                begin
                    $display("%0t: unexpected beat %h", $time, out_data);
                    errs = errs + 1;
                end
                else
                begin
                    want = position_queue.pop_front();
                    if (want.x_position !== out_data.x_position)
                    begin
                        $display("%0t: x_position expected %0d actual %0d", $time,
                                 want.x_position, out_data.x_position);
                        errs = errs + 1;
                    end
                    if (want.y_position !== out_data.y_position)
                    begin
                        $display("%0t: y_position expected %0d actual %0d", $time,
                                 want.y_position, out_data.y_position);
                        errs = errs + 1;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// top of the joystick axis normalizer testbench: clock, reset, apb writes, stimulus, verdict
// depends on jan_pkg, joystick_axis_normalizer and axis_checker
module testbench;
    import jan_pkg::*;

    localparam int LATENCY = 2 * FRAC_BITS + 6;
    localparam int CYCLE_LIMIT = 200000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_beat_t             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_beat_t            out_data;
    int                   fail_count;
    int                   pending_positions;
    int                   cycle_count = 0;
    bit                   sink_calm = 1'b0;

    joystick_axis_normalizer dut (.*);

    axis_checker checker_i (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver stalls for a random stretch, possibly none, before every beat, unless told to stay open
    initial
    begin
        int hold;
        forever
        begin
            @(negedge clk);
            if (out_valid)
            begin
                hold = sink_calm ? 0 : $urandom_range(0, 11);
                out_stall <= hold != 0;
                repeat (hold) @(negedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
                while (!out_valid) @(posedge clk);
            end
        end
    end

    task automatic write_register(input logic [2:0] index, input logic [DATA_BITS-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_axes(input int xlo, input int xhi, input int ylo, input int yhi,
                            input int xt, input int yt, input int xb, input int yb);
        write_register(REG_X_MIN, xlo);
        write_register(REG_X_MAX, xhi);
        write_register(REG_Y_MIN, ylo);
        write_register(REG_Y_MAX, yhi);
        write_register(REG_X_TRIM, xt);
        write_register(REG_Y_TRIM, yt);
        write_register(REG_X_BAND, xb);
        write_register(REG_Y_BAND, yb);
    endtask

    task automatic send_pair(input int xs, input int ys, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 11) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data.x_sample <= SAMPLE_BITS'(xs);
        in_data.y_sample <= SAMPLE_BITS'(ys);
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_positions != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic int random_trim();
        return $urandom_range(0, 16384) - 8192;
    endfunction

    initial
    begin
        int phase;
        int k;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset config, corners, center, then zero span, reversed span, big band
        send_pair(0, 0, 0);
        send_pair(4095, 4095, 0);
        send_pair(1650, 1650, 0);
        send_pair(3300, 0, 0);
        send_pair(1651, 1649, 0);
        drain();
        set_axes(2000, 2000, 4095, 0, 8192, -8192, 16000, 0);
        send_pair(2000, 0, 0);
        send_pair(4095, 4095, 0);
        send_pair(0, 2048, 0);
        send_pair(2047, 1000, 0);
        drain();
        set_axes(0, 4095, 100, 200, -8192, 8192, 0, 16383);
        send_pair(0, 4095, 0);
        send_pair(4095, 150, 0);
        send_pair(2048, 149, 0);
        send_pair(2047, 151, 0);
        send_pair(1024, 0, 0);
        drain();
        // register bits above the field width are dropped by the block
        set_axes(32'hFFFF_F000, 32'hFFFF_FFFF, 32'h1234_5000, 32'h0000_1FFF,
                 32'hFFFF_C000, 32'h0001_3FFF, 32'hFFFF_FFFF, 32'h0000_C000);
        send_pair(1, 4094, 0);
        send_pair(2730, 1365, 0);
        send_pair(4095, 0, 0);
        drain();

        for (phase = 0; phase < 10; phase++)
        begin
            if (phase == 9)
                set_axes(0, 3300, 0, 3300, 0, 0, 0, 0);
            else
                set_axes($urandom_range(0, 1800), $urandom_range(2200, 4095),
                         $urandom_range(0, 4095), $urandom_range(0, 4095),
                         random_trim(), random_trim(),
                         $urandom_range(0, 3) == 0 ? 16383 : $urandom_range(0, 16000),
                         $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6000));
            sink_calm = phase == 4;
            for (k = 0; k < 75; k++)
                send_pair($urandom_range(0, 4095), $urandom_range(0, 4095), phase % 3 != 0);
            drain();
        end
        sink_calm = 1'b0;

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
